### design/spfp_pkg.sv
// Package for the softplus fp32 unit: per-item state layout, the per-stage
// micro-instruction table and the binary32 arithmetic helpers used by each cell.
// Depends on nothing.
package spfp_pkg;

  localparam int unsigned NUM_SLOTS  = 7;
  localparam int unsigned NUM_STAGES = 62;

  // State slots that travel with an item down the chain.
  localparam logic [2:0] SLOT_M  = 3'd0;  // max(x,0), later the result
  localparam logic [2:0] SLOT_X  = 3'd1;
  localparam logic [2:0] SLOT_FX = 3'd2;
  localparam logic [2:0] SLOT_T  = 3'd3;
  localparam logic [2:0] SLOT_Z  = 3'd4;
  localparam logic [2:0] SLOT_Y  = 3'd5;
  localparam logic [2:0] SLOT_E  = 3'd6;
  localparam logic [2:0] SRC_K   = 3'd7;  // operand is the instruction constant

  localparam logic [31:0] K_ZERO      = 32'h0000_0000;
  localparam logic [31:0] K_NEG_ZERO  = 32'h8000_0000;
  localparam logic [31:0] K_ONE       = 32'h3f80_0000;
  localparam logic [31:0] K_NEG_ONE   = 32'hbf80_0000;
  localparam logic [31:0] K_HALF      = 32'h3f00_0000;
  localparam logic [31:0] K_QNAN      = 32'h7fc0_0000;
  localparam logic [31:0] K_EXP_HI    = 32'h42b0_c0a5;
  localparam logic [31:0] K_EXP_LO    = 32'hc2b0_c0a5;
  localparam logic [31:0] K_LOG2E     = 32'h3fb8_aa3b;
  localparam logic [31:0] K_MAGIC     = 32'h4b40_0000;
  localparam logic [31:0] K_LN2_HI    = 32'h3f31_8000;
  localparam logic [31:0] K_LN2_LO    = 32'hb95e_8083;
  localparam logic [31:0] K_MIN_NORM  = 32'h0080_0000;
  localparam logic [31:0] K_MANT_MASK = 32'h007f_ffff;
  localparam logic [31:0] K_HALF_EXP  = 32'h3f00_0000;
  localparam logic [31:0] K_SQRT_HALF = 32'h3f35_04f3;
  localparam logic [31:0] K_P0 = 32'h3950_6967;
  localparam logic [31:0] K_P1 = 32'h3ab7_43ce;
  localparam logic [31:0] K_P2 = 32'h3c08_8908;
  localparam logic [31:0] K_P3 = 32'h3d2a_a9c1;
  localparam logic [31:0] K_P4 = 32'h3e2a_aaaa;
  localparam logic [31:0] K_P5 = 32'h3f00_0000;
  localparam logic [31:0] K_Q0 = 32'h3d90_21bb;
  localparam logic [31:0] K_Q1 = 32'hbdeb_d1b8;
  localparam logic [31:0] K_Q2 = 32'h3def_251a;
  localparam logic [31:0] K_Q3 = 32'hbdfe_5d4f;
  localparam logic [31:0] K_Q4 = 32'h3e11_e9bf;
  localparam logic [31:0] K_Q5 = 32'hbe2a_ae50;
  localparam logic [31:0] K_Q6 = 32'h3e4c_ceac;
  localparam logic [31:0] K_Q7 = 32'hbe7f_fffc;
  localparam logic [31:0] K_Q8 = 32'h3eaa_aaaa;

  typedef enum logic [3:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_MIN,
    OP_MAX,
    OP_POW2,   // dst = 2^n for the integer-valued float a, zero on underflow
    OP_EXPF,   // dst = float(unbiased exponent of a non-negative a)
    OP_MANT,   // dst = mantissa of a forced into [0.5,1)
    OP_FOLD,   // dst = (a < b) ? a : 0
    OP_COND    // dst = a - ((b != 0) ? 1 : 0)
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [2:0]  dst;
    logic [2:0]  sa;
    logic [2:0]  sb;
    logic [31:0] k;
  } instr_t;

  typedef struct packed {
    logic                       last;
    logic [NUM_SLOTS-1:0][31:0] slot;
  } state_t;

  function automatic instr_t mk(op_e op, logic [2:0] d, logic [2:0] sa, logic [2:0] sb,
                                logic [31:0] k);
    instr_t i;
    i.op  = op;
    i.dst = d;
    i.sa  = sa;
    i.sb  = sb;
    i.k   = k;
    return i;
  endfunction

  // One binary32 operation per stage, in evaluation order.
  function automatic instr_t prog(int unsigned s);
    case (s)
      0:  return mk(OP_MAX,  SLOT_M,  SLOT_M,  SRC_K,   K_ZERO);
      1:  return mk(OP_MIN,  SLOT_X,  SLOT_X,  SRC_K,   K_EXP_HI);
      2:  return mk(OP_MAX,  SLOT_X,  SLOT_X,  SRC_K,   K_EXP_LO);
      3:  return mk(OP_MUL,  SLOT_FX, SLOT_X,  SRC_K,   K_LOG2E);
      4:  return mk(OP_ADD,  SLOT_FX, SLOT_FX, SRC_K,   K_MAGIC);
      5:  return mk(OP_SUB,  SLOT_FX, SLOT_FX, SRC_K,   K_MAGIC);
      6:  return mk(OP_MUL,  SLOT_T,  SLOT_FX, SRC_K,   K_LN2_HI);
      7:  return mk(OP_SUB,  SLOT_X,  SLOT_X,  SLOT_T,  K_ZERO);
      8:  return mk(OP_MUL,  SLOT_T,  SLOT_FX, SRC_K,   K_LN2_LO);
      9:  return mk(OP_SUB,  SLOT_X,  SLOT_X,  SLOT_T,  K_ZERO);
      10: return mk(OP_MUL,  SLOT_Z,  SLOT_X,  SLOT_X,  K_ZERO);
      11: return mk(OP_MUL,  SLOT_Y,  SRC_K,   SLOT_X,  K_P0);
      12: return mk(OP_ADD,  SLOT_Y,  SLOT_Y,  SRC_K,   K_P1);
      13: return mk(OP_MUL,  SLOT_Y,  SLOT_Y,  SLOT_X,  K_ZERO);
      14: return mk(OP_ADD,  SLOT_Y,  SLOT_Y,  SRC_K,   K_P2);
      15: return mk(OP_MUL,  SLOT_Y,  SLOT_Y,  SLOT_X,  K_ZERO);
      16: return mk(OP_ADD,  SLOT_Y,  SLOT_Y,  SRC_K,   K_P3);
      17: return mk(OP_MUL,  SLOT_Y,  SLOT_Y,  SLOT_X,  K_ZERO);
      18: return mk(OP_ADD,  SLOT_Y,  SLOT_Y,  SRC_K,   K_P4);
      19: return mk(OP_MUL,  SLOT_Y,  SLOT_Y,  SLOT_X,  K_ZERO);
      20: return mk(OP_ADD,  SLOT_Y,  SLOT_Y,  SRC_K,   K_P5);
      21: return mk(OP_MUL,  SLOT_Y,  SLOT_Y,  SLOT_Z,  K_ZERO);
      22: return mk(OP_ADD,  SLOT_Y,  SLOT_Y,  SLOT_X,  K_ZERO);
      23: return mk(OP_ADD,  SLOT_Y,  SLOT_Y,  SRC_K,   K_ONE);
      24: return mk(OP_POW2, SLOT_T,  SLOT_FX, SLOT_FX, K_ZERO);
      25: return mk(OP_MUL,  SLOT_Y,  SLOT_Y,  SLOT_T,  K_ZERO);
      26: return mk(OP_ADD,  SLOT_X,  SLOT_Y,  SRC_K,   K_ONE);
      27: return mk(OP_MAX,  SLOT_X,  SLOT_X,  SRC_K,   K_MIN_NORM);
      28: return mk(OP_EXPF, SLOT_E,  SLOT_X,  SLOT_X,  K_ZERO);
      29: return mk(OP_MANT, SLOT_X,  SLOT_X,  SLOT_X,  K_ZERO);
      30: return mk(OP_ADD,  SLOT_E,  SLOT_E,  SRC_K,   K_ONE);
      31: return mk(OP_FOLD, SLOT_T,  SLOT_X,  SRC_K,   K_SQRT_HALF);
      32: return mk(OP_SUB,  SLOT_X,  SLOT_X,  SRC_K,   K_ONE);
      33: return mk(OP_COND, SLOT_E,  SLOT_E,  SLOT_T,  K_ZERO);
      34: return mk(OP_ADD,  SLOT_X,  SLOT_X,  SLOT_T,  K_ZERO);
      35: return mk(OP_MUL,  SLOT_Z,  SLOT_X,  SLOT_X,  K_ZERO);
      36: return mk(OP_MUL,  SLOT_Y,  SRC_K,   SLOT_X,  K_Q0);
      37: return mk(OP_ADD,  SLOT_Y,  SLOT_Y,  SRC_K,   K_Q1);
      38: return mk(OP_MUL,  SLOT_Y,  SLOT_Y,  SLOT_X,  K_ZERO);
      39: return mk(OP_ADD,  SLOT_Y,  SLOT_Y,  SRC_K,   K_Q2);
      40: return mk(OP_MUL,  SLOT_Y,  SLOT_Y,  SLOT_X,  K_ZERO);
      41: return mk(OP_ADD,  SLOT_Y,  SLOT_Y,  SRC_K,   K_Q3);
      42: return mk(OP_MUL,  SLOT_Y,  SLOT_Y,  SLOT_X,  K_ZERO);
      43: return mk(OP_ADD,  SLOT_Y,  SLOT_Y,  SRC_K,   K_Q4);
      44: return mk(OP_MUL,  SLOT_Y,  SLOT_Y,  SLOT_X,  K_ZERO);
      45: return mk(OP_ADD,  SLOT_Y,  SLOT_Y,  SRC_K,   K_Q5);
      46: return mk(OP_MUL,  SLOT_Y,  SLOT_Y,  SLOT_X,  K_ZERO);
      47: return mk(OP_ADD,  SLOT_Y,  SLOT_Y,  SRC_K,   K_Q6);
      48: return mk(OP_MUL,  SLOT_Y,  SLOT_Y,  SLOT_X,  K_ZERO);
      49: return mk(OP_ADD,  SLOT_Y,  SLOT_Y,  SRC_K,   K_Q7);
      50: return mk(OP_MUL,  SLOT_Y,  SLOT_Y,  SLOT_X,  K_ZERO);
      51: return mk(OP_ADD,  SLOT_Y,  SLOT_Y,  SRC_K,   K_Q8);
      52: return mk(OP_MUL,  SLOT_Y,  SLOT_Y,  SLOT_X,  K_ZERO);
      53: return mk(OP_MUL,  SLOT_Y,  SLOT_Y,  SLOT_Z,  K_ZERO);
      54: return mk(OP_MUL,  SLOT_T,  SLOT_E,  SRC_K,   K_LN2_LO);
      55: return mk(OP_ADD,  SLOT_Y,  SLOT_Y,  SLOT_T,  K_ZERO);
      56: return mk(OP_MUL,  SLOT_T,  SLOT_Z,  SRC_K,   K_HALF);
      57: return mk(OP_SUB,  SLOT_Y,  SLOT_Y,  SLOT_T,  K_ZERO);
      58: return mk(OP_ADD,  SLOT_X,  SLOT_X,  SLOT_Y,  K_ZERO);
      59: return mk(OP_MUL,  SLOT_T,  SLOT_E,  SRC_K,   K_LN2_HI);
      60: return mk(OP_ADD,  SLOT_X,  SLOT_X,  SLOT_T,  K_ZERO);
      61: return mk(OP_ADD,  SLOT_M,  SLOT_M,  SLOT_X,  K_ZERO);
      // Adding negative zero leaves any non-NaN value unchanged.
      default: return mk(OP_ADD, SLOT_M, SLOT_M, SRC_K, K_NEG_ZERO);
    endcase
  endfunction

  function automatic logic is_nan(logic [31:0] u);
    return (u[30:23] == 8'hff) && (u[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(logic [31:0] u);
    return (u[30:23] == 8'hff) && (u[22:0] == 23'd0);
  endfunction

  // Ordered less-than on non-NaN values; both zeros compare equal.
  function automatic logic flt(logic [31:0] a, logic [31:0] b);
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return 1'b0;
    if (a[31] != b[31]) return a[31];
    if (!a[31]) return a[30:0] < b[30:0];
    return a[30:0] > b[30:0];
  endfunction

  function automatic logic feq(logic [31:0] a, logic [31:0] b);
    return (a == b) || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0));
  endfunction

  function automatic logic [31:0] fmax(logic [31:0] a, logic [31:0] b);
    if (is_nan(a) && is_nan(b)) return K_QNAN;
    if (is_nan(a)) return b;
    if (is_nan(b)) return a;
    if (feq(a, b)) return a & b;
    return flt(a, b) ? b : a;
  endfunction

  function automatic logic [31:0] fmin(logic [31:0] a, logic [31:0] b);
    if (is_nan(a) && is_nan(b)) return K_QNAN;
    if (is_nan(a)) return b;
    if (is_nan(b)) return a;
    if (feq(a, b)) return a | b;
    return flt(a, b) ? a : b;
  endfunction

  // Normalize and round to nearest even. Bit 48 of m carries weight 2^(e-127).
  function automatic logic [31:0] round_pack(logic sign, logic signed [11:0] e,
                                             logic [49:0] m);
    logic [5:0]         lz;
    logic [49:0]        mn;
    logic [49:0]        lost;
    logic signed [11:0] ex;
    logic [11:0]        sh;
    logic               sticky;
    logic [23:0]        mant;
    logic               rnd;
    logic [31:0]        pk;
    if (m == 50'd0) return {sign, 31'd0};
    lz = 6'd0;
    for (int i = 0; i < 50; i++) begin
      if (m[i]) lz = 6'(49 - i);
    end
    mn = m << lz;
    ex = e + 12'sd1 - $signed({6'd0, lz});
    sticky = 1'b0;
    if (ex <= 12'sd0) begin
      sh = 12'(12'sd1 - ex);
      if (sh >= 12'd50) begin
        sticky = |mn;
        mn = 50'd0;
      end else begin
        lost = mn & ((50'd1 << sh) - 50'd1);
        sticky = |lost;
        mn = mn >> sh;
      end
      ex = 12'sd1;
    end
    if (ex >= 12'sd255) return {sign, 8'hff, 23'd0};
    mant = mn[49:26];
    rnd = mn[25] & (sticky | (|mn[24:0]) | mant[0]);
    pk = (32'(ex - 12'sd1) << 23) + {8'd0, mant} + {31'd0, rnd};
    return {sign, pk[30:0]};
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    logic               sign;
    logic [23:0]        ma;
    logic [23:0]        mb;
    logic [47:0]        p;
    logic signed [11:0] e;
    sign = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return K_QNAN;
    if ((is_inf(a) && (b[30:0] == 31'd0)) || (is_inf(b) && (a[30:0] == 31'd0))) begin
      return K_QNAN;
    end
    if (is_inf(a) || is_inf(b)) return {sign, 8'hff, 23'd0};
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    p  = ma * mb;
    e  = $signed({4'd0, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]})
       + $signed({4'd0, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]}) - 12'sd127;
    return round_pack(sign, e, {p, 2'b00});
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  eb;
    logic [7:0]  es;
    logic [7:0]  d;
    logic [49:0] xb;
    logic [49:0] ys;
    logic [49:0] s;
    if (is_nan(a) || is_nan(b)) return K_QNAN;
    if (is_inf(a) && is_inf(b) && (a[31] != b[31])) return K_QNAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] < b[30:0]) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d  = eb - es;
    xb = {1'b0, big[30:23] != 8'd0, big[22:0], 25'd0};
    ys = {1'b0, sml[30:23] != 8'd0, sml[22:0], 25'd0};
    if (d >= 8'd50) begin
      ys = {49'd0, |ys};
    end else begin
      ys = (ys >> d) | {49'd0, |(ys & ((50'd1 << d) - 50'd1))};
    end
    if (big[31] == sml[31]) begin
      s = xb + ys;
    end else begin
      s = xb - ys;
      if (s == 50'd0) return K_ZERO;
    end
    return round_pack(big[31], $signed({4'd0, eb}), s);
  endfunction

  // 2^n for an integer-valued float n; n + 127 below zero gives zero.
  function automatic logic [31:0] pow2_of(logic [31:0] f);
    logic [23:0]        mag;
    logic signed [25:0] n;
    logic signed [25:0] nb;
    if (f[30:23] < 8'd127) begin
      mag = 24'd0;
    end else if (f[30:23] > 8'd150) begin
      mag = 24'hff_ffff;
    end else begin
      mag = {1'b1, f[22:0]} >> (8'd150 - f[30:23]);
    end
    n  = f[31] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    nb = n + 26'sd127;
    if (nb < 26'sd0) return K_ZERO;
    return {nb[8:0], 23'd0};
  endfunction

  // Unbiased exponent field of a non-negative f, converted to float (always exact).
  function automatic logic [31:0] expf_of(logic [31:0] f);
    logic signed [9:0] ei;
    logic [9:0]        mag;
    logic [3:0]        msb;
    logic [32:0]       sh;
    ei  = $signed({1'b0, f[31:23]}) - 10'sd127;
    mag = ei[9] ? 10'(-ei) : 10'(ei);
    if (mag == 10'd0) return K_ZERO;
    msb = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (mag[i]) msb = 4'(i);
    end
    sh = {23'd0, mag} << (5'd23 - {1'b0, msb});
    return {ei[9], 8'(8'd127 + {4'd0, msb}), sh[22:0]};
  endfunction

endpackage

### design/softplus_fp32_unit.sv
// Top level of the softplus fp32 unit: a chain of spfp_cell stages, one binary32
// operation per cell. Depends on spfp_pkg and spfp_cell.
//
// Channel   Dir  Signals                         Payload
// s_axis    in   tvalid, tready, tdata, tlast    tdata = x_bits, tlast = last_in
// m_axis    out  tvalid, tready, tdata, tlast    tdata = y_bits, tlast = last_out
//
// Each request passes through 62 cells in order, each of which registers it. Its result
// is presented from the last cell's register and is taken when m_axis_tready is high.
// The chain takes one request every cycle unless stalled; each cell holds one item in flight.
// A stall on m_axis backs up cell by cell: a cell accepts whenever it is empty or
// its neighbor takes its item, so empty slots in the chain still fill up.
// Reset clears only the valid flag of each cell; the item state needs no reset.
module softplus_fp32_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] x_bits
  input  logic        s_axis_tlast,   // last_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] y_bits
  output logic        m_axis_tlast    // last_out
);

  localparam int unsigned N = spfp_pkg::NUM_STAGES;

  spfp_pkg::state_t chain_data [N+1];
  logic             chain_valid [N+1];
  logic             chain_ready [N+1];

  // The first cell sees x in the M slot and the clamp input -|x| in the X slot; the
  // sign is forced here since it is a plain bit operation.
  always_comb begin
    chain_data[0].last = s_axis_tlast;
    chain_data[0].slot = '0;
    chain_data[0].slot[spfp_pkg::SLOT_M] = s_axis_tdata;
    chain_data[0].slot[spfp_pkg::SLOT_X] = {1'b1, s_axis_tdata[30:0]};
  end

  assign chain_valid[0] = s_axis_tvalid;
  assign s_axis_tready  = chain_ready[0];

  for (genvar g = 0; g < N; g++) begin : g_cell
    spfp_cell #(
      .STAGE(g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (chain_valid[g]),
      .in_ready_o (chain_ready[g]),
      .in_data_i  (chain_data[g]),
      .out_valid_o(chain_valid[g+1]),
      .out_ready_i(chain_ready[g+1]),
      .out_data_o (chain_data[g+1])
    );
  end

  // The final cell's register is the output register.
  assign chain_ready[N] = m_axis_tready;
  assign m_axis_tvalid  = chain_valid[N];
  assign m_axis_tdata   = chain_data[N].slot[spfp_pkg::SLOT_M];
  assign m_axis_tlast   = chain_data[N].last;

`ifndef SYNTH
  // The input can only be held off when the whole chain is full and stalled.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a stalled result");

  // NaN inputs are clamped away, so a result is never NaN.
  a_no_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !((m_axis_tdata[30:23] == 8'hff) && (m_axis_tdata[22:0] != 23'd0)))
    else $error("NaN result");

  // Softplus never goes negative.
  a_non_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[31])
    else $error("negative result");
`endif

endmodule

### design/spfp_cell.sv
// One cell of the softplus chain: performs its stage's binary32 operation on the
// item state and hands the item to the next cell. Depends on spfp_pkg.
module spfp_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spfp_pkg::state_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spfp_pkg::state_t  out_data_o
);

  localparam spfp_pkg::instr_t Ins = spfp_pkg::prog(STAGE);

  logic             valid_q;
  spfp_pkg::state_t data_q;
  spfp_pkg::state_t data_d;
  logic [31:0]      opa;
  logic [31:0]      opb;
  logic [31:0]      res;

  assign opa = (Ins.sa == spfp_pkg::SRC_K) ? Ins.k : in_data_i.slot[Ins.sa];
  assign opb = (Ins.sb == spfp_pkg::SRC_K) ? Ins.k : in_data_i.slot[Ins.sb];

  always_comb begin
    case (Ins.op)
      spfp_pkg::OP_ADD:  res = spfp_pkg::fp_add(opa, opb);
      spfp_pkg::OP_SUB:  res = spfp_pkg::fp_add(opa, {~opb[31], opb[30:0]});
      spfp_pkg::OP_MUL:  res = spfp_pkg::fp_mul(opa, opb);
      spfp_pkg::OP_MIN:  res = spfp_pkg::fmin(opa, opb);
      spfp_pkg::OP_MAX:  res = spfp_pkg::fmax(opa, opb);
      spfp_pkg::OP_POW2: res = spfp_pkg::pow2_of(opa);
      spfp_pkg::OP_EXPF: res = spfp_pkg::expf_of(opa);
      spfp_pkg::OP_MANT: res = (opa & spfp_pkg::K_MANT_MASK) | spfp_pkg::K_HALF_EXP;
      spfp_pkg::OP_FOLD: res = spfp_pkg::flt(opa, opb) ? opa : spfp_pkg::K_ZERO;
      spfp_pkg::OP_COND: res = spfp_pkg::fp_add(opa, (opb != 32'd0) ?
                                 spfp_pkg::K_NEG_ONE : spfp_pkg::K_NEG_ZERO);
      default:           res = opa;
    endcase
  end

  always_comb begin
    data_d = in_data_i;
    data_d.slot[Ins.dst] = res;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
